@@ hw/rtl/a85_pkg.sv @@
// Shared types and constants for the Ascii85 stream decoder.
`default_nettype none

package a85_pkg;

  // Status codes carried on the closing beat of a stream
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_Z_IN_GROUP = 3'd1,
    ST_BAD_CHAR   = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_LONE       = 3'd4
  } status_t;

  // Character codes
  localparam logic [7:0] CH_FIRST = 8'h21;  // '!' digit 0
  localparam logic [7:0] CH_LAST  = 8'h75;  // 'u' digit 84
  localparam logic [7:0] CH_Z     = 8'h7A;  // 'z' four zero bytes

  // Group geometry
  localparam logic [2:0] GROUP_LAST_DIGIT = 3'd4;  // digit count before the fifth digit
  localparam logic [2:0] GROUP_BYTES      = 3'd4;

  // Padding factors 85^k for a partial group of two, three or four digits
  localparam logic [19:0] PAD_FOR_2 = 20'd614125;
  localparam logic [19:0] PAD_FOR_3 = 20'd7225;
  localparam logic [19:0] PAD_FOR_4 = 20'd85;

  // Port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  // One queued job for the output side: up to four bytes, then optionally the status beat
  typedef struct packed {
    logic [31:0] value;       // group value, bytes taken from the top down
    logic [2:0]  nbytes;      // bytes to send, 0..4
    logic        dec;         // value is one above the group (padded flush)
    logic        has_status;  // send the status beat after the bytes
    status_t     code;
    logic [31:0] count;       // saturated byte count for the status beat
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/a85_front.sv @@
// Input side: digit classification, group accumulation, error and byte count state.
`default_nettype none

module a85_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic          kind,
  input  wire logic [7:0]    code_char,
  output logic               push,
  output a85_pkg::cmd_t      cmd
);
  import a85_pkg::*;

  logic [25:0] acc_r, acc_nxt;
  logic [2:0]  dcnt_r, dcnt_nxt;
  status_t     err_r, err_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  logic [6:0]  digit;
  logic [32:0] grp_v;
  logic [26:0] acc_p1;
  logic [19:0] pad_f;
  logic [46:0] prod;
  logic [2:0]  addend;
  logic [32:0] sum;
  logic [31:0] cnt_sat;
  logic        is_digit;

  // Digit value and next group value: acc*85 + d as shifts and adds
  assign digit    = 7'(code_char - CH_FIRST);
  assign is_digit = (code_char >= CH_FIRST) && (code_char <= CH_LAST);
  assign grp_v    = {1'b0, acc_r, 6'b0} + {3'b0, acc_r, 4'b0} + {5'b0, acc_r, 2'b0}
                  + {7'b0, acc_r} + {26'b0, digit};

  // Flush value plus one: (acc+1) * 85^(5-n)
  always_comb begin
    case (dcnt_r)
      3'd2:    pad_f = PAD_FOR_2;
      3'd3:    pad_f = PAD_FOR_3;
      default: pad_f = PAD_FOR_4;
    endcase
  end
  assign acc_p1 = {1'b0, acc_r} + 27'd1;
  assign prod   = {20'b0, acc_p1} * {27'b0, pad_f};

  // Saturating byte count
  assign addend  = kind ? 3'(dcnt_r - 3'd1) : GROUP_BYTES;
  assign sum     = {1'b0, cnt_r} + {30'b0, addend};
  assign cnt_sat = sum[32] ? '1 : sum[31:0];

  // Next state and queued job
  always_comb begin
    acc_nxt  = acc_r;
    dcnt_nxt = dcnt_r;
    err_nxt  = err_r;
    cnt_nxt  = cnt_r;
    push     = 1'b0;
    cmd      = '0;
    if (accept) begin
      if (!kind) begin
        if (err_r == ST_OK) begin
          if (code_char == CH_Z) begin
            if (dcnt_r != 3'd0) begin
              err_nxt = ST_Z_IN_GROUP;
            end else begin
              push       = 1'b1;
              cmd.nbytes = GROUP_BYTES;
              cnt_nxt    = cnt_sat;
            end
          end else if (!is_digit) begin
            err_nxt = ST_BAD_CHAR;
          end else if (dcnt_r == GROUP_LAST_DIGIT) begin
            acc_nxt  = '0;
            dcnt_nxt = '0;
            if (grp_v[32]) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              push       = 1'b1;
              cmd.value  = grp_v[31:0];
              cmd.nbytes = GROUP_BYTES;
              cnt_nxt    = cnt_sat;
            end
          end else begin
            acc_nxt  = grp_v[25:0];
            dcnt_nxt = dcnt_r + 3'd1;
          end
        end
      end else begin
        // End of stream: optional flush, then status; state returns to reset
        push           = 1'b1;
        cmd.has_status = 1'b1;
        cmd.dec        = 1'b1;
        cmd.value      = prod[31:0];
        cmd.code       = err_r;
        cmd.count      = cnt_r;
        if (err_r == ST_OK && dcnt_r == 3'd1) begin
          cmd.code = ST_LONE;
        end else if (err_r == ST_OK && dcnt_r > 3'd1) begin
          if (prod[32]) begin
            cmd.code = ST_OVERFLOW;
          end else begin
            cmd.nbytes = 3'(dcnt_r - 3'd1);
            cmd.count  = cnt_sat;
          end
        end
        acc_nxt  = '0;
        dcnt_nxt = '0;
        err_nxt  = ST_OK;
        cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      dcnt_r <= '0;
      err_r  <= ST_OK;
      cnt_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      dcnt_r <= dcnt_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/a85_queue.sv @@
// Short job queue between the input side and the output side.
`default_nettype none

module a85_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire a85_pkg::cmd_t din,
  input  wire logic          pop,
  output logic               full,
  output logic               nonempty,
  output a85_pkg::cmd_t      dout
);
  import a85_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  assign full     = (fill_r == CW'(DEPTH));
  assign nonempty = (fill_r != '0);
  assign dout     = mem[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + CW'(1);
      2'b01:   fill_nxt = fill_r - CW'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/a85_back.sv @@
// Output side: splits a queued job into byte beats and the closing status beat.
`default_nettype none

module a85_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_valid,
  input  wire a85_pkg::cmd_t                        q_cmd,
  output logic                                      q_pop,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [a85_pkg::OUT_TDATA_W-1:0]           out_tdata,
  output logic [a85_pkg::OUT_TUSER_W-1:0]           out_tuser,
  output logic                                      out_tlast
);
  import a85_pkg::*;

  logic          busy_r, busy_nxt;
  logic [2:0]    left_r, left_nxt;
  logic          stat_r, stat_nxt;
  logic [31:0]   val_r, val_nxt;
  status_t       code_r, code_nxt;
  logic [31:0]   cnt_r, cnt_nxt;

  logic          is_byte;
  logic          beat_last;
  logic          fire;
  logic          done;

  assign is_byte   = (left_r != 3'd0);
  assign beat_last = (left_r == 3'd1 && !stat_r) || !is_byte;
  assign fire      = busy_r && out_tready;
  assign done      = fire && beat_last;
  assign q_pop     = (!busy_r || done) && q_valid;

  // Beat payload
  assign out_tvalid = busy_r;
  assign out_tlast  = beat_last;
  assign out_tuser  = {!is_byte, is_byte};
  assign out_tdata  = is_byte ? {40'b0, val_r[31:24]}
                              : {5'b0, cnt_r, code_r, 8'b0};

  // Job sequencing
  always_comb begin
    busy_nxt = busy_r;
    left_nxt = left_r;
    stat_nxt = stat_r;
    val_nxt  = val_r;
    code_nxt = code_r;
    cnt_nxt  = cnt_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      left_nxt = q_cmd.nbytes;
      stat_nxt = q_cmd.has_status;
      val_nxt  = q_cmd.value - {31'b0, q_cmd.dec};
      code_nxt = q_cmd.code;
      cnt_nxt  = q_cmd.count;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      left_nxt = left_r - 3'd1;
      val_nxt  = {val_r[23:0], 8'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    stat_r <= stat_nxt;
    val_r  <= val_nxt;
    code_r <= code_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/ascii85_stream_decoder.sv @@
// Ascii85 decoder top level: input side, job queue and output side.
// A character that completes a group is queued; out_tvalid rises once the output side pops it.
// Throughput: one input beat per cycle unless the queue is full; one output beat per cycle when
// out_tready is high; the QUEUE_DEPTH-job queue absorbs the four beats of a 'z' or fifth digit.
// An end beat gives up to three flush bytes and a status beat (tlast on the final beat).
// Reset (rst_n low, synchronous) clears the group, error and count state and empties the queue.
`default_nettype none

module ascii85_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [a85_pkg::IN_TDATA_W-1:0]       in_tdata,   // [7:0] code_char
  input  wire logic                                 in_tuser,   // [0] kind
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [a85_pkg::OUT_TDATA_W-1:0]           out_tdata,  // [7:0] data_byte,
                                                                // [10:8] status,
                                                                // [42:11] byte_count
  output logic [a85_pkg::OUT_TUSER_W-1:0]           out_tuser,  // [0] byte_valid,
                                                                // [1] end_of_stream
  output logic                                      out_tlast   // last
);
  import a85_pkg::*;

  logic  q_full;
  logic  q_nonempty;
  logic  q_pop;
  logic  push;
  cmd_t  push_cmd;
  cmd_t  head_cmd;

  assign in_tready = !q_full;

  a85_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_tvalid && in_tready),
    .kind      (in_tuser),
    .code_char (in_tdata),
    .push      (push),
    .cmd       (push_cmd)
  );

  a85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .din      (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .dout     (head_cmd)
  );

  a85_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_nonempty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ hw/rtl/a85_checker.sv @@
// Port-level checks for the Ascii85 decoder, bound to the top level.
`default_nettype none

module a85_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic [a85_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic [a85_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  wire logic                                 out_tlast
);

  // A stalled output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // The status beat closes the stream and is always the final beat of its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tuser[1])
    else $error("status beat without end flag or tlast");

  // A byte beat carries no status, no count and no end flag
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1] && out_tdata[42:8] == 35'd0)
    else $error("byte beat carries status fields");

  // Padding bits of tdata stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:43] == 5'd0)
    else $error("tdata padding not zero");

endmodule

bind ascii85_stream_decoder a85_checker u_a85_checker (.*);

`default_nettype wire
